>>> src/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants
// Widths, character codes and the controller/datapath interface structs for
// the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  // Fixed width of the value port.
  localparam int INPUT_BITS = 64;
  // Number of low bits of value that are converted (8 to 64).
  localparam int VALUE_BITS = 64;

  // Magnitude bits converted per cycle by the double dabble step.
  localparam int STEP_BITS = 4;
  localparam int PAD_BITS  = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int STEPS     = PAD_BITS / STEP_BITS;
  localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
  localparam int DIGITS   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS = DIGITS * 4;
  localparam int IDX_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic load;
    logic step;
    logic calc_len;
    logic push_sign;
    logic push_digit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic negative;
    logic final_digit;
    logic out_free;
  } status_t;

endpackage

>>> src/sbda_ctrl.sv
// ----------------------------------------------------------------------------
// sbda_ctrl: conversion sequencer
// Steps one value through accept, binary to BCD conversion, length search,
// sign output and digit output.
// ----------------------------------------------------------------------------
module sbda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sbda_pkg::status_t status,
  output sbda_pkg::cmd_t    cmd
);
  import sbda_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (status.step_last) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.calc_len = 1'b1;
        state_next   = status.negative ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.push_sign = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.push_digit = 1'b1;
          if (status.final_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/sbda_datapath.sv
// ----------------------------------------------------------------------------
// sbda_datapath: magnitude, BCD and output registers
// Converts the magnitude to BCD by double dabble, STEP_BITS bits per cycle, and
// drives the character output register.
// ----------------------------------------------------------------------------
module sbda_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [sbda_pkg::INPUT_BITS-1:0] value,
  input  sbda_pkg::cmd_t                       cmd,
  output sbda_pkg::status_t                    status,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           character,
  output logic                                 last
);
  import sbda_pkg::*;

  logic [PAD_BITS-1:0]   mag;
  logic [PAD_BITS-1:0]   mag_step;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] raw_abs;
  logic                  negative;
  logic [STEP_W-1:0]     step_cnt;
  bcd_t                  bcd;
  bcd_t                  bcd_step;
  logic [IDX_W-1:0]      dig_idx;
  logic [IDX_W-1:0]      top_idx;

  assign raw     = value[VALUE_BITS-1:0];
  assign raw_abs = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  // Double dabble: per bit, add three to each digit of five or more, then
  // shift the next magnitude bit into the BCD word.
  always_comb begin
    logic [BCD_BITS-1:0] flat;
    bcd_step = bcd;
    mag_step = mag;
    for (int j = 0; j < STEP_BITS; j++) begin
      for (int i = 0; i < DIGITS; i++) begin
        if (bcd_step[i] >= 4'd5) begin
          bcd_step[i] = bcd_step[i] + 4'd3;
        end
      end
      flat     = bcd_step;
      flat     = {flat[BCD_BITS-2:0], mag_step[PAD_BITS-1]};
      bcd_step = flat;
      mag_step = {mag_step[PAD_BITS-2:0], 1'b0};
    end
  end

  // Position of the most significant nonzero digit; zero gives position 0.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= PAD_BITS'(raw_abs);
      negative <= raw[VALUE_BITS-1];
      bcd      <= '0;
      step_cnt <= '0;
    end else if (cmd.step) begin
      mag      <= mag_step;
      bcd      <= bcd_step;
      step_cnt <= step_cnt + STEP_W'(1);
    end
    if (cmd.calc_len) begin
      dig_idx <= top_idx;
    end else if (cmd.push_digit) begin
      dig_idx <= dig_idx - IDX_W'(1);
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_sign || cmd.push_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.push_digit) begin
      character <= CHAR_ZERO + {4'd0, bcd[dig_idx]};
      last      <= (dig_idx == '0);
    end
  end

  assign status.step_last   = (step_cnt == STEP_W'(STEPS - 1));
  assign status.negative    = negative;
  assign status.final_digit = (dig_idx == '0);
  assign status.out_free    = !out_valid || !out_stall;

endmodule

>>> src/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
// 16 BCD steps of 4 bits and a length search, then one character per cycle
// while the output is not stalled; no new value until the last character.
// Synchronous reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sbda_pkg::INPUT_BITS-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           character,
  output logic                                 last
);
  import sbda_pkg::*;

  cmd_t    cmd;
  status_t status;

  sbda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sbda_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule

>>> sim/signed_binary_to_decimal_ascii_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_test: self-checking bench for the converter
// Feeds signed 64-bit values through a valid/stall driver and checks every
// character and last flag against a local decimal formatter. The run steps
// through several sender-idle and receiver-stall mixes, including a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_test;
  import sbda_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [INPUT_BITS-1:0] value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   character;
  logic                         last;

  logic [63:0] pending_values[$];
  text_char_t  expected_text[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  int          hold_left = 0;

  signed_binary_to_decimal_ascii i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  always #4 clk = ~clk;

  // Appends the decimal text of one value, most significant character first.
  task automatic queue_decimal_text(input logic [63:0] word_in);
    logic [63:0] field_mask;
    logic [63:0] raw;
    logic [63:0] mag;
    logic        negative;
    logic [7:0]  digit_chars[$];
    text_char_t  entry;
    field_mask = {64{1'b1}} >> (64 - VALUE_BITS);
    raw = word_in & field_mask;
    negative = raw[VALUE_BITS-1];
    // The most negative value wraps to its own bit pattern, which is the
    // correct unsigned magnitude.
    mag = negative ? ((~raw + 64'd1) & field_mask) : raw;
    do begin
      digit_chars.push_front(CHAR_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (negative) begin
      entry.character = CHAR_MINUS;
      entry.last = 1'b0;
      expected_text.push_back(entry);
    end
    while (digit_chars.size() > 0) begin
      entry.character = digit_chars.pop_front();
      entry.last = (digit_chars.size() == 0);
      expected_text.push_back(entry);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0d] mismatch: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic logic [63:0] power_of_ten(input int exponent);
    logic [63:0] p;
    p = 64'd1;
    repeat (exponent) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          pick;
    pick = $urandom_range(99);
    v = {$urandom, $urandom};
    if (pick < 40) begin
      return v;
    end else if (pick < 85) begin
      // Short magnitudes give short texts; negate half of them.
      v = v >> $urandom_range(63);
      return $urandom_range(1) ? -v : v;
    end else if (pick < 93) begin
      v = power_of_ten($urandom_range(18)) + 64'($urandom_range(2)) - 64'd1;
      return $urandom_range(1) ? -v : v;
    end else begin
      v = {1'b0, {63{1'b1}}} - 64'($urandom_range(3));
      return $urandom_range(1) ? v : ~v;
    end
  endfunction

  // Driver: predicts each accepted word, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        queue_decimal_text(value);
      end
      if (!in_valid || !in_stall) begin
        if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_request && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: each accepted word is checked against the oldest expectation.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected word character=%0d last=%0b",
                                  character, last));
      end else begin
        want = expected_text.pop_front();
        if (character !== want.character) begin
          report_mismatch($sformatf("character %0d, expected %0d",
                                    character, want.character));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL signed_binary_to_decimal_ascii");
      $finish;
    end
  end

  task automatic wait_for_idle();
    while (pending_values.size() > 0 || in_valid || expected_text.size() > 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random_phase(input int send_idle, input int recv_stall,
                                  input int count, input logic with_hold);
    @(negedge clk);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    repeat (count) pending_values.push_back(random_value());
    if (with_hold) begin
      hold_request = 1'b1;
      @(negedge clk);
      hold_request = 1'b0;
    end
    wait_for_idle();
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed values: zero, small values, digit-count edges and both extremes.
    @(negedge clk);
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(-64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(-64'd10);
    pending_values.push_back(64'd99);
    pending_values.push_back(-64'd100);
    pending_values.push_back({1'b0, {63{1'b1}}});
    pending_values.push_back({1'b1, {63{1'b0}}});
    pending_values.push_back({1'b1, 62'd0, 1'b1});
    pending_values.push_back({1'b0, {62{1'b1}}, 1'b0});
    for (k = 17; k <= 18; k++) begin
      pending_values.push_back(power_of_ten(k));
      pending_values.push_back(power_of_ten(k) - 64'd1);
      pending_values.push_back(-power_of_ten(k));
      pending_values.push_back(-(power_of_ten(k) - 64'd1));
    end
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    wait_for_idle();

    run_random_phase(0, 0, 50, 1'b0);
    run_random_phase(65, 0, 50, 1'b0);
    run_random_phase(0, 65, 50, 1'b0);
    run_random_phase(28, 28, 60, 1'b0);
    run_random_phase(0, 0, 40, 1'b1);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS signed_binary_to_decimal_ascii");
    end else begin
      $display("FAIL signed_binary_to_decimal_ascii");
    end
    $finish;
  end

endmodule
